>>> rtl/evad_pkg.sv
// shared types and constants for the energy voice activity detector
`default_nettype none
package evad_pkg;

    localparam int FRAME_SAMPLES = 512;
    localparam int CNT_W = $clog2(FRAME_SAMPLES + 1);
    localparam int SUM_W = 40;
    localparam int FLOOR_W = 27;
    localparam int RQ_W = 32;
    localparam logic [FLOOR_W-1:0] FLOOR_CAP_Q16 = FLOOR_W'(1200) << 16;
    localparam logic [10:0] UP_RATE_Q16 = 11'd1966;

    localparam logic [1:0] CFG_WARMUP = 2'd0;
    localparam logic [1:0] CFG_SNR = 2'd1;
    localparam logic [1:0] CFG_RMS_MIN = 2'd2;
    localparam logic [1:0] CFG_TRIGGER = 2'd3;

    typedef enum logic [6:0] {
        ST_ACC   = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_SQRT  = 7'b0000100,
        ST_FLOOR = 7'b0001000,
        ST_WDIV  = 7'b0010000,
        ST_THR   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic acc_en;
        logic start_div;
        logic div_step;
        logic start_sqrt;
        logic sqrt_step;
        logic do_floor;
        logic start_wdiv;
        logic wdiv_step;
        logic do_thr;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic frame_close;
        logic step_last;
        logic latched;
        logic warm;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/evad_datapath.sv
// datapath: frame accumulator, serial divider, serial square root, floor and threshold
`default_nettype none
module evad_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  evad_pkg::ctrl_t          ctrl,
    output evad_pkg::stat_t          stat,
    input  wire logic signed [15:0]  sample,
    input  wire logic                frame_end,
    input  wire logic [7:0]          warmup_frames,
    input  wire logic [11:0]         snr_factor,
    input  wire logic [14:0]         rms_min,
    input  wire logic [7:0]          trigger_frames,
    output logic [15:0]              frame_rms,
    output logic [14:0]              level_threshold,
    output logic                     above_threshold,
    output logic                     warming_up,
    output logic                     voice_triggered,
    output logic [10:0]              floor_level
);
    import evad_pkg::*;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]   quo_reg, quo_next;
    logic [CNT_W:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]   dvs_reg;
    logic [5:0]         step_reg, step_next;
    logic [SUM_W-1:0]   sx_reg, sx_next;
    logic [SUM_W-1:0]   sres_reg, sres_next;
    logic [SUM_W-1:0]   sbit_reg, sbit_next;
    logic [FLOOR_W-1:0] floor_reg, floor_next;
    logic [7:0]         seen_reg;
    logic [7:0]         run_reg;
    logic               latch_reg;
    logic [14:0]        held_reg;
    logic [14:0]        thr_reg;
    logic               above_reg, warm_reg;
    logic [RQ_W:0]      wq_reg, wq_next;
    logic [8:0]         wr_reg, wr_next;
    logic               wup_reg;
    logic [15:0]        rms_reg;
    logic [15:0]        mag;
    logic [31:0]        sq;
    logic [CNT_W-1:0]   cnt_inc;
    logic [CNT_W+1:0]   rem_sh;
    logic [SUM_W-1:0]   s_trial;
    logic [RQ_W-1:0]    rq;
    logic [RQ_W-1:0]    floor_ext;
    logic [RQ_W-1:0]    diff;
    logic [RQ_W+10:0]   up_prod;
    logic [RQ_W-1:0]    fl_tmp;
    logic [9:0]         wr_sh;
    logic [8:0]         wdv;
    logic [FLOOR_W+11:0] thr_prod;
    logic [14:0]        thr_val;
    logic               thr_above;

    assign mag = sample[15] ? 16'(-sample) : 16'(sample);
    assign sq = mag * mag;
    assign cnt_inc = cnt_reg + 1'b1;
    assign stat.frame_close = frame_end || (cnt_inc == CNT_W'(FRAME_SAMPLES));
    assign stat.latched = latch_reg;
    assign stat.warm = seen_reg < warmup_frames;
    assign stat.step_last = (step_reg == 6'd0);
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign s_trial = sres_reg + sbit_reg;
    assign rq = RQ_W'(rms_reg) << 16;
    assign floor_ext = RQ_W'(floor_reg);
    assign diff = (rq >= floor_ext) ? rq - floor_ext : floor_ext - rq;
    assign up_prod = diff * UP_RATE_Q16;
    assign wdv = {1'b0, seen_reg} + 9'd1;
    assign wr_sh = {wr_reg, wq_reg[RQ_W]};
    assign thr_prod = floor_reg * snr_factor;
    assign thr_val = (thr_prod[FLOOR_W+11:24] < {1'b0, rms_min}) ? rms_min
                     : 15'(thr_prod[FLOOR_W+11:24]);
    assign thr_above = {1'b0, rms_reg} > {2'b00, (latch_reg ? held_reg : thr_val)};

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        sx_next = sx_reg;
        sres_next = sres_reg;
        sbit_next = sbit_reg;
        wq_next = wq_reg;
        wr_next = wr_reg;
        floor_next = floor_reg;
        fl_tmp = floor_ext;
        if (ctrl.acc_en)
        begin
            sum_next = sum_reg + SUM_W'(sq);
            cnt_next = cnt_inc;
        end
        if (ctrl.start_div)
        begin
            quo_next = sum_reg + SUM_W'(sq);
            rem_next = '0;
            step_next = 6'(SUM_W - 1);
            sum_next = '0;
            cnt_next = '0;
        end
        if (ctrl.div_step)
        begin
            if (rem_sh >= (CNT_W+2)'(dvs_reg))
            begin
                rem_next = (CNT_W+1)'(rem_sh - (CNT_W+2)'(dvs_reg));
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = (CNT_W+1)'(rem_sh);
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 6'd1;
        end
        if (ctrl.start_sqrt)
        begin
            sx_next = quo_reg;
            sres_next = '0;
            sbit_next = SUM_W'(1) << (SUM_W - 2);
            step_next = 6'(SUM_W / 2 - 1);
        end
        if (ctrl.sqrt_step)
        begin
            if (sx_reg >= s_trial)
            begin
                sx_next = sx_reg - s_trial;
                sres_next = (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_next = sres_reg >> 1;
            sbit_next = sbit_reg >> 2;
            step_next = step_reg - 6'd1;
        end
        if (ctrl.do_floor)
        begin
            if (rq < floor_ext)
                fl_tmp = floor_ext - (diff >> 1);
            else
                fl_tmp = floor_ext + RQ_W'(up_prod >> 16);
            floor_next = (fl_tmp > RQ_W'(FLOOR_CAP_Q16)) ? FLOOR_CAP_Q16
                                                         : FLOOR_W'(fl_tmp);
        end
        if (ctrl.start_wdiv)
        begin
            wq_next = {1'b0, diff};
            wr_next = '0;
            step_next = 6'(RQ_W);
        end
        if (ctrl.wdiv_step)
        begin
            if (wr_sh >= {1'b0, wdv})
            begin
                wr_next = 9'(wr_sh - {1'b0, wdv});
                wq_next = {wq_reg[RQ_W-1:0], 1'b1};
            end
            else
            begin
                wr_next = 9'(wr_sh);
                wq_next = {wq_reg[RQ_W-1:0], 1'b0};
            end
            step_next = step_reg - 6'd1;
            if (step_reg == 6'd0)
            begin
                fl_tmp = wup_reg ? floor_ext + RQ_W'(wq_next)
                                 : floor_ext - RQ_W'(wq_next);
                floor_next = (fl_tmp > RQ_W'(FLOOR_CAP_Q16)) ? FLOOR_CAP_Q16
                                                             : FLOOR_W'(fl_tmp);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            floor_reg <= '0;
            seen_reg <= '0;
            run_reg <= '0;
            latch_reg <= 1'b0;
            held_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            floor_reg <= floor_next;
            step_reg <= step_next;
            if (ctrl.wdiv_step && step_reg == 6'd0)
                seen_reg <= seen_reg + 8'd1;
            if (ctrl.do_thr && !latch_reg)
            begin
                if (thr_above)
                begin
                    if ((run_reg == 8'd255 ? run_reg : run_reg + 8'd1) >= trigger_frames)
                    begin
                        latch_reg <= 1'b1;
                        held_reg <= thr_val;
                    end
                    if (run_reg != 8'd255)
                        run_reg <= run_reg + 8'd1;
                end
                else
                    run_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        sx_reg <= sx_next;
        sres_reg <= sres_next;
        sbit_reg <= sbit_next;
        wq_reg <= wq_next;
        wr_reg <= wr_next;
        if (ctrl.start_div)
            dvs_reg <= cnt_inc;
        if (ctrl.sqrt_step && step_reg == 6'd0)
            rms_reg <= 16'(sres_next);
        if (ctrl.start_wdiv)
            wup_reg <= rq >= floor_ext;
        if (ctrl.do_thr)
        begin
            thr_reg <= latch_reg ? held_reg : thr_val;
            above_reg <= thr_above;
            warm_reg <= 1'b0;
        end
        if (ctrl.start_wdiv)
        begin
            thr_reg <= '0;
            above_reg <= 1'b0;
            warm_reg <= 1'b1;
        end
        if (ctrl.load_out)
        begin
            frame_rms <= rms_reg;
            level_threshold <= thr_reg;
            above_threshold <= above_reg;
            warming_up <= warm_reg;
            voice_triggered <= latch_reg;
            floor_level <= floor_reg[26:16];
        end
    end

`ifndef ASSERT_OFF
    a_floor_cap: assert property (@(posedge clk) disable iff (!rst_n)
        floor_reg <= FLOOR_CAP_Q16) else $error("floor above cap");
    a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg |=> latch_reg) else $error("trigger latch dropped");
    a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg |=> $stable(floor_reg)) else $error("floor moved after latch");
`endif
endmodule
`default_nettype wire

>>> rtl/evad_ctrl.sv
// controller state machine sequencing accumulate, divide, root and floor update
`default_nettype none
module evad_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  evad_pkg::stat_t  stat,
    output evad_pkg::ctrl_t  ctrl
);
    import evad_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   take;

    assign in_ready = (state_reg == ST_ACC);
    assign out_valid = ov_reg;
    assign take = in_valid && in_ready;

    always_comb
    begin
        ctrl = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        unique case (state_reg)
            ST_ACC:
            begin
                ctrl.acc_en = take;
                if (take && stat.frame_close)
                begin
                    ctrl.start_div = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (stat.step_last)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                ctrl.start_sqrt = 1'b1;
                state_next = ST_FLOOR;
            end
            ST_FLOOR:
            begin
                ctrl.sqrt_step = 1'b1;
                if (stat.step_last)
                    state_next = ST_WDIV;
            end
            ST_WDIV:
            begin
                if (stat.latched)
                begin
                    ctrl.do_thr = 1'b1;
                    state_next = ST_OUT;
                end
                else if (stat.warm)
                begin
                    ctrl.start_wdiv = 1'b1;
                    state_next = ST_THR;
                end
                else
                begin
                    ctrl.do_floor = 1'b1;
                    state_next = ST_THR;
                end
            end
            ST_THR:
            begin
                if (stat.warm && !stat.latched)
                begin
                    ctrl.wdiv_step = 1'b1;
                    if (stat.step_last)
                        state_next = ST_OUT;
                end
                else
                begin
                    ctrl.do_thr = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ctrl.load_out = 1'b1;
                    ov_next = 1'b1;
                    state_next = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

`ifndef ASSERT_OFF
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |=> out_valid) else $error("result lost");
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.acc_en |-> state_reg == ST_ACC) else $error("accumulate outside frame");
`endif
endmodule
`default_nettype wire

>>> rtl/energy_voice_activity_detector.sv
// top level of the energy voice activity detector
// after the closing sample the controller runs a 40-step divide and a 20-step square root,
// then the floor update (33-step divide in warm-up, skipped once latched) and out_valid
// throughput: one sample a cycle within a frame; input stalls from frame close until
// the result is loaded, longer while the previous result waits
// reset: asynchronous active low, clears sums, floor, counters, latch, registers to defaults
`default_nettype none
module energy_voice_activity_detector (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [15:0] sample,
    input  wire logic               frame_end,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             frame_rms,
    output logic [14:0]             level_threshold,
    output logic                    above_threshold,
    output logic                    warming_up,
    output logic                    voice_triggered,
    output logic [10:0]             floor_level,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [14:0]        cfg_data
);
    import evad_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic [7:0]  warmup_reg;
    logic [11:0] snr_reg;
    logic [14:0] rmin_reg;
    logic [7:0]  trig_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg <= 8'd8;
            snr_reg <= 12'd768;
            rmin_reg <= 15'd300;
            trig_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WARMUP:  warmup_reg <= cfg_data[7:0];
                CFG_SNR:     snr_reg <= cfg_data[11:0];
                CFG_RMS_MIN: rmin_reg <= cfg_data;
                CFG_TRIGGER: trig_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    evad_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .ctrl(ctrl)
    );

    evad_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .sample(sample), .frame_end(frame_end),
        .warmup_frames(warmup_reg), .snr_factor(snr_reg), .rms_min(rmin_reg),
        .trigger_frames(trig_reg),
        .frame_rms(frame_rms), .level_threshold(level_threshold),
        .above_threshold(above_threshold), .warming_up(warming_up),
        .voice_triggered(voice_triggered), .floor_level(floor_level)
    );
endmodule
`default_nettype wire
